// File: src/rastrigin_objective_accumulator_macros.svh
// Assertion macros shared by the accumulator modules.
`ifndef RASTRIGIN_OBJECTIVE_ACCUMULATOR_MACROS_SVH
`define RASTRIGIN_OBJECTIVE_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("roa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ROA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("roa assertion failed");

`endif

// File: src/roa_pkg.sv
package roa_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned COS_W       = 16;
  localparam int unsigned SUM_W       = 24;
  localparam int unsigned ACC_W       = 26;
  localparam int unsigned W10_W       = 19;
  localparam int unsigned COS_ONE     = 16384;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = 2;
  localparam int unsigned CNT_W       = 3;

  localparam logic [SUM_W-1:0] SUM_MAX    = '1;
  localparam logic [63:0]      TWO_PI_Q30 = 64'd6746518852;

  // Divide a series term by (2n-1)(2n) for n from 1 to 8; other n pass it unchanged.
  function automatic logic [63:0] series_div(input logic [63:0] t, input int unsigned n);
    logic [63:0] q;
    case (n)
      1:       q = t / 64'd2;
      2:       q = t / 64'd12;
      3:       q = t / 64'd30;
      4:       q = t / 64'd56;
      5:       q = t / 64'd90;
      6:       q = t / 64'd132;
      7:       q = t / 64'd182;
      8:       q = t / 64'd240;
      default: q = t;
    endcase
    return q;
  endfunction

  // Cosine of 2*pi*k/2^pb in signed Q2.14, built from a Taylor series in Q30.
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned k, input int unsigned pb);
    int unsigned  size;
    int unsigned  m;
    logic         neg;
    logic [63:0]  th;
    logic [63:0]  th2;
    logic [63:0]  t;
    longint       acc;
    logic [63:0]  c;
    int unsigned  v;
    logic [COS_W-1:0] r;
    size = 1 << pb;
    m    = k;
    neg  = 1'b0;
    if (m > size / 2) m = size - m;
    if (m > size / 4) begin
      m   = size / 2 - m;
      neg = 1'b1;
    end
    th  = (64'(m) * TWO_PI_Q30) >> pb;
    th2 = (th * th) >> 30;
    t   = 64'd1 << 30;
    acc = longint'(t);
    for (int unsigned n = 1; n <= 8; n++) begin
      t = (t * th2) >> 30;
      t = series_div(t, n);
      if (n % 2 == 1) acc = acc - longint'(t);
      else            acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    c = 64'(acc);
    v = 32'((c + (64'd1 << 15)) >> 16);
    if (v > COS_ONE) v = COS_ONE;
    r = COS_W'(v);
    if (neg) r = COS_W'(-r);
    return r;
  endfunction

endpackage

// File: src/roa_front.sv
module roa_front #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned PHASE_BITS = 10,
  parameter int unsigned SQ_W       = 31 - FRAC_BITS,
  parameter int unsigned ENTRY_W    = 1 + roa_pkg::COS_W + SQ_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [roa_pkg::COORD_W-1:0]  coord,
  input  logic                         last,
  input  logic                         coord_valid,
  output logic                         coord_stall,
  output logic                         push,
  output logic [ENTRY_W-1:0]           push_data,
  input  logic                         queue_full
);

  localparam int unsigned TABLE_SIZE = 1 << PHASE_BITS;

  typedef logic [roa_pkg::COS_W-1:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
      r[k] = roa_pkg::cos_entry(k, PHASE_BITS);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  logic                       stage_valid;
  logic                       stage_last;
  logic [SQ_W-1:0]            stage_square;
  logic [roa_pkg::COS_W-1:0]  stage_cos;
  logic                       accept;
  logic [PHASE_BITS-1:0]      idx;
  logic [16:0]                mag;
  logic [30:0]                sq;
  logic [30:0]                sq_round;

  assign coord_stall = stage_valid && queue_full;
  assign accept      = coord_valid && !coord_stall;
  assign push        = stage_valid && !queue_full;
  assign push_data   = {stage_last, stage_cos, stage_square};

  // Phase index: top fraction bits, the two's complement wraps negatives correctly
  generate
    if (PHASE_BITS <= FRAC_BITS) begin : g_idx_sel
      assign idx = coord[FRAC_BITS-1 -: PHASE_BITS];
    end else begin : g_idx_pad
      assign idx = {coord[FRAC_BITS-1:0], {(PHASE_BITS - FRAC_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    mag      = coord[15] ? (17'({1'b0, ~coord}) + 17'd1) : 17'(coord);
    sq       = 31'(mag) * 31'(mag);
    sq_round = sq + (31'd1 << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_last   <= last;
      stage_square <= SQ_W'(sq_round >> FRAC_BITS);
      stage_cos    <= COS_ROM[idx];
    end
  end

endmodule

// File: src/roa_queue.sv
`include "rastrigin_objective_accumulator_macros.svh"

module roa_queue #(
  parameter int unsigned WIDTH = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [WIDTH-1:0]  head_data
);

  logic [WIDTH-1:0]             mem [roa_pkg::QUEUE_DEPTH];
  logic [roa_pkg::PTR_W-1:0]    wr_ptr;
  logic [roa_pkg::PTR_W-1:0]    rd_ptr;
  logic [roa_pkg::CNT_W-1:0]    count;

  assign full       = count == roa_pkg::CNT_W'(roa_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + roa_pkg::PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + roa_pkg::PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + roa_pkg::CNT_W'(1);
        2'b01:   count <= count - roa_pkg::CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ROA_ASSERT_SAME(a_no_overrun, push, count != roa_pkg::CNT_W'(roa_pkg::QUEUE_DEPTH))
  `ROA_ASSERT_SAME(a_no_underrun, pop, count != '0)

endmodule

// File: src/roa_back.sv
`include "rastrigin_objective_accumulator_macros.svh"

module roa_back #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned SQ_W      = 31 - FRAC_BITS,
  parameter int unsigned ENTRY_W   = 1 + roa_pkg::COS_W + SQ_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  logic [ENTRY_W-1:0]          head_data,
  output logic                        pop,
  output logic [roa_pkg::SUM_W-1:0]   total,
  output logic                        saturated,
  output logic                        result_valid,
  input  logic                        result_stall
);

  localparam int unsigned WAVE_W = (FRAC_BITS > 14) ? roa_pkg::W10_W + FRAC_BITS - 14
                                                    : roa_pkg::W10_W;

  logic [roa_pkg::SUM_W-1:0]  running_sum;
  logic                       clamp_seen;
  logic                       head_last;
  logic [roa_pkg::COS_W-1:0]  head_cos;
  logic [SQ_W-1:0]            head_square;
  logic [16:0]                diff_s;
  logic [19:0]                w10;
  logic [WAVE_W-1:0]          wave;
  logic [roa_pkg::ACC_W-1:0]  sum;
  logic                       over;
  logic [roa_pkg::SUM_W-1:0]  sum_clamped;
  logic                       clamp_next;

  assign {head_last, head_cos, head_square} = head_data;

  // A result transaction can only be produced when the output register is free
  assign pop = head_valid && (!head_last || !result_valid || !result_stall);

  always_comb begin
    diff_s = 17'd16384 - {head_cos[15], head_cos};
    w10    = ({3'b000, diff_s} << 3) + ({3'b000, diff_s} << 1);
  end

  generate
    if (FRAC_BITS < 14) begin : g_wave_rnd
      logic [19:0] w_round;
      assign w_round = w10 + (20'd1 << (13 - FRAC_BITS));
      assign wave    = WAVE_W'(w_round >> (14 - FRAC_BITS));
    end else begin : g_wave_shl
      assign wave = WAVE_W'(w10[roa_pkg::W10_W-1:0]) << (FRAC_BITS - 14);
    end
  endgenerate

  always_comb begin
    sum         = roa_pkg::ACC_W'(running_sum) + roa_pkg::ACC_W'(head_square)
                + roa_pkg::ACC_W'(wave);
    over        = sum > roa_pkg::ACC_W'(roa_pkg::SUM_MAX);
    sum_clamped = over ? roa_pkg::SUM_MAX : sum[roa_pkg::SUM_W-1:0];
    clamp_next  = clamp_seen || over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      clamp_seen   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        // Clear the point state after its final coordinate
        running_sum <= head_last ? '0 : sum_clamped;
        clamp_seen  <= head_last ? 1'b0 : clamp_next;
      end
      if (pop && head_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_last) begin
      total     <= sum_clamped;
      saturated <= clamp_next;
    end
  end

  `ROA_ASSERT_SAME(a_clamp_pins_sum, clamp_seen, running_sum == roa_pkg::SUM_MAX)
  `ROA_ASSERT_SAME(a_sat_total, result_valid && saturated, total == roa_pkg::SUM_MAX)
  `ROA_ASSERT_NEXT(a_point_clear, pop && head_last, running_sum == '0 && !clamp_seen)

endmodule

// File: src/rastrigin_objective_accumulator.sv
// Rastrigin objective accumulator.
// Input channel (coord, last, coord_valid, coord_stall): one signed coordinate
// per transaction, last marks the final coordinate of a point. Output channel
// (total, saturated, result_valid, result_stall): one transaction per point,
// the saturated objective sum and a flag set if the sum was clamped.
// Throughput: one coordinate per cycle while coord_stall is low. The front
// stage squares the coordinate and reads the cosine ROM in the accepting cycle;
// a 4-entry queue feeds the back stage, which adds and saturates one coordinate
// per cycle but holds a last coordinate while a result is stalled. The result is
// registered after the last coordinate leaves the front register and the queue.
// While result_stall is high the result is held; coordinates keep flowing until
// the next last coordinate reaches the back stage, then the queue fills and
// coord_stall rises.
// Reset (synchronous) empties the queue, drops any pending result and clears
// the running sum and clamp flag. The cosine ROM is constant and needs no fill.
module rastrigin_objective_accumulator #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned PHASE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [roa_pkg::COORD_W-1:0] coord,
  input  logic                        last,
  input  logic                        coord_valid,
  output logic                        coord_stall,
  output logic [roa_pkg::SUM_W-1:0]   total,
  output logic                        saturated,
  output logic                        result_valid,
  input  logic                        result_stall
);

  localparam int unsigned SQ_W    = 31 - FRAC_BITS;
  localparam int unsigned ENTRY_W = 1 + roa_pkg::COS_W + SQ_W;

  logic                push;
  logic [ENTRY_W-1:0]  push_data;
  logic                queue_full;
  logic                pop;
  logic                head_valid;
  logic [ENTRY_W-1:0]  head_data;

  roa_front #(
    .FRAC_BITS  (FRAC_BITS),
    .PHASE_BITS (PHASE_BITS),
    .SQ_W       (SQ_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .coord       (coord),
    .last        (last),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .push        (push),
    .push_data   (push_data),
    .queue_full  (queue_full)
  );

  roa_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  roa_back #(
    .FRAC_BITS (FRAC_BITS),
    .SQ_W      (SQ_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .total        (total),
    .saturated    (saturated),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
